// ===== rtl/core/ppsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsr_pkg
// Shared types and constants for the binary PPM stream reader: character
// codes, parser phases, result kinds and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppsr_pkg;

    // Largest dimension the image geometry may carry.
    localparam int DIM_BITS = 16;
    localparam logic [24:0] DIM_MAX = 25'((26'(1) << DIM_BITS) - 26'(1));

    // Numbers saturate at this value.
    localparam logic [15:0] NUM_CAP = 16'hFFFF;
    localparam logic [15:0] MAXVAL_REQUIRED = 16'd255;

    // Character codes.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_COMMENT,
        PH_TOKEN,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        MAGIC_NONE,
        MAGIC_P,
        MAGIC_OK,
        MAGIC_BAD
    } magic_t;

    // Ordered by severity: a higher code overrides a lower one.
    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_SIZE = 2'd1,
        FAULT_BAD  = 2'd2
    } fault_t;

    typedef enum logic [2:0] {
        KIND_PIXEL  = 3'd0,
        KIND_HEADER = 3'd1,
        KIND_BAD    = 3'd2,
        KIND_TRUNC  = 3'd3,
        KIND_SIZE   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        last;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } result_t;

endpackage

// ===== rtl/core/ppsr_parser.sv =====
// ----------------------------------------------------------------------------
// ppsr_parser
// Header tokenizer, number reader and pixel grouper. Updates the parse state
// for each accepted byte and presents at most one result in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppsr_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_file,
    input  logic [15:0]          max_width,
    input  logic [15:0]          max_height,
    output logic                 res_valid,
    output ppsr_pkg::result_t    res
);

    ppsr_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       tok_reg, tok_next;
    ppsr_pkg::magic_t magic_reg, magic_next;
    logic             neg_reg, neg_next;
    logic             dig_reg, dig_next;
    logic             closed_reg, closed_next;
    logic [15:0]      numv_reg, numv_next;
    logic [15:0]      img_w_reg, img_w_next;
    logic [15:0]      img_h_reg, img_h_next;
    ppsr_pkg::fault_t fault_reg, fault_next;
    logic [15:0]      col_reg, col_next;
    logic [15:0]      row_reg, row_next;
    logic [1:0]       comp_reg, comp_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       green_reg, green_next;

    function automatic ppsr_pkg::fault_t raise_fault(ppsr_pkg::fault_t cur,
                                                     ppsr_pkg::fault_t f);
        return (f > cur) ? f : cur;
    endfunction

    // Byte classes.
    logic is_ws, is_hash, is_digit;
    assign is_ws    = (data_byte == ppsr_pkg::CH_SPACE) ||
                      (data_byte >= ppsr_pkg::CH_TAB && data_byte <= ppsr_pkg::CH_CR);
    assign is_hash  = (data_byte == ppsr_pkg::CH_HASH);
    assign is_digit = (data_byte >= ppsr_pkg::CH_ZERO) && (data_byte <= ppsr_pkg::CH_NINE);

    // Decimal accumulator. A token that starts on this byte begins from zero.
    logic [15:0] dig_base;
    logic        dig_closed;
    logic        dig_take;
    logic [19:0] dig_sum;
    logic [15:0] dig_value;
    assign dig_base   = (phase_reg == ppsr_pkg::PH_SKIP) ? 16'd0 : numv_reg;
    assign dig_closed = (phase_reg == ppsr_pkg::PH_SKIP) ? 1'b0 : closed_reg;
    assign dig_take   = !dig_closed && is_digit;
    assign dig_sum    = 20'({dig_base, 3'b000}) + 20'({dig_base, 1'b0})
                      + 20'(data_byte - ppsr_pkg::CH_ZERO);
    assign dig_value  = (dig_sum > 20'(ppsr_pkg::NUM_CAP)) ? ppsr_pkg::NUM_CAP
                                                           : dig_sum[15:0];

    // Dimension range checks on the number collected so far.
    logic size_bad_w, size_bad_h, size_bad_any;
    assign size_bad_any = (neg_reg && numv_reg != 16'd0) ||
                          (25'(numv_reg) > ppsr_pkg::DIM_MAX);
    assign size_bad_w   = size_bad_any || (numv_reg > max_width);
    assign size_bad_h   = size_bad_any || (numv_reg > max_height);

    // Pixel position arithmetic.
    logic [16:0] col_inc, row_inc;
    logic        pix_last, row_end;
    assign col_inc  = 17'(col_reg) + 17'd1;
    assign row_inc  = 17'(row_reg) + 17'd1;
    assign pix_last = (col_inc == 17'(img_w_reg)) && (row_inc == 17'(img_h_reg));
    assign row_end  = (col_inc >= 17'(img_w_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= ppsr_pkg::PH_SKIP;
            tok_reg    <= '0;
            magic_reg  <= ppsr_pkg::MAGIC_NONE;
            neg_reg    <= 1'b0;
            dig_reg    <= 1'b0;
            closed_reg <= 1'b0;
            numv_reg   <= '0;
            img_w_reg  <= '0;
            img_h_reg  <= '0;
            fault_reg  <= ppsr_pkg::FAULT_NONE;
            col_reg    <= '0;
            row_reg    <= '0;
            comp_reg   <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            tok_reg    <= tok_next;
            magic_reg  <= magic_next;
            neg_reg    <= neg_next;
            dig_reg    <= dig_next;
            closed_reg <= closed_next;
            numv_reg   <= numv_next;
            img_w_reg  <= img_w_next;
            img_h_reg  <= img_h_next;
            fault_reg  <= fault_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            comp_reg   <= comp_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

    always_comb begin
        ppsr_pkg::fault_t cf;
        logic [15:0]      cw;
        logic [15:0]      ch;

        phase_next  = phase_reg;
        tok_next    = tok_reg;
        magic_next  = magic_reg;
        neg_next    = neg_reg;
        dig_next    = dig_reg;
        closed_next = closed_reg;
        numv_next   = numv_reg;
        img_w_next  = img_w_reg;
        img_h_next  = img_h_reg;
        fault_next  = fault_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        comp_next   = comp_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        res_valid   = 1'b0;
        res         = '0;

        // Verdict on the current token if it were closed now.
        cf = fault_reg;
        cw = img_w_reg;
        ch = img_h_reg;
        unique case (tok_reg)
            2'd0: begin
                if (magic_reg != ppsr_pkg::MAGIC_OK) begin
                    cf = raise_fault(cf, ppsr_pkg::FAULT_BAD);
                end
            end
            2'd1: begin
                if (!dig_reg) begin
                    cf = raise_fault(cf, ppsr_pkg::FAULT_BAD);
                    cw = '0;
                end else if (size_bad_w) begin
                    cf = raise_fault(cf, ppsr_pkg::FAULT_SIZE);
                    cw = '0;
                end else begin
                    cw = numv_reg;
                end
            end
            2'd2: begin
                if (!dig_reg) begin
                    cf = raise_fault(cf, ppsr_pkg::FAULT_BAD);
                    ch = '0;
                end else if (size_bad_h) begin
                    cf = raise_fault(cf, ppsr_pkg::FAULT_SIZE);
                    ch = '0;
                end else begin
                    ch = numv_reg;
                end
            end
            default: begin
                if (!dig_reg || neg_reg || numv_reg != ppsr_pkg::MAXVAL_REQUIRED) begin
                    cf = raise_fault(cf, ppsr_pkg::FAULT_BAD);
                end
            end
        endcase

        if (in_fire) begin
            if (end_of_file) begin
                priority if (phase_reg == ppsr_pkg::PH_SKIP ||
                             phase_reg == ppsr_pkg::PH_COMMENT ||
                             (phase_reg == ppsr_pkg::PH_TOKEN && tok_reg != 2'd3)) begin
                    res_valid = 1'b1;
                    res.kind  = ppsr_pkg::KIND_BAD;
                    res.last  = 1'b1;
                end else if (phase_reg == ppsr_pkg::PH_TOKEN) begin
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    if (cf != ppsr_pkg::FAULT_NONE) begin
                        res.kind = (cf == ppsr_pkg::FAULT_BAD) ? ppsr_pkg::KIND_BAD
                                                               : ppsr_pkg::KIND_SIZE;
                    end else if (cw == 16'd0 || ch == 16'd0) begin
                        res.kind   = ppsr_pkg::KIND_HEADER;
                        res.column = cw;
                        res.row    = ch;
                    end else begin
                        res.kind = ppsr_pkg::KIND_TRUNC;
                    end
                end else if (phase_reg == ppsr_pkg::PH_PIXELS) begin
                    res_valid  = 1'b1;
                    res.kind   = ppsr_pkg::KIND_TRUNC;
                    res.last   = 1'b1;
                    res.column = col_reg;
                    res.row    = row_reg;
                end else begin
                    res_valid = 1'b0;
                end

                // The reader rearms for the next file.
                phase_next  = ppsr_pkg::PH_SKIP;
                tok_next    = '0;
                magic_next  = ppsr_pkg::MAGIC_NONE;
                neg_next    = 1'b0;
                dig_next    = 1'b0;
                closed_next = 1'b0;
                numv_next   = '0;
                img_w_next  = '0;
                img_h_next  = '0;
                fault_next  = ppsr_pkg::FAULT_NONE;
                col_next    = '0;
                row_next    = '0;
                comp_next   = '0;
                red_next    = '0;
                green_next  = '0;
            end else begin
                unique case (phase_reg)
                    ppsr_pkg::PH_SKIP: begin
                        if (is_hash) begin
                            phase_next = ppsr_pkg::PH_COMMENT;
                        end else if (!is_ws) begin
                            phase_next  = ppsr_pkg::PH_TOKEN;
                            neg_next    = 1'b0;
                            dig_next    = 1'b0;
                            closed_next = 1'b0;
                            numv_next   = '0;
                            if (tok_reg == 2'd0) begin
                                magic_next = (data_byte == ppsr_pkg::CH_P)
                                           ? ppsr_pkg::MAGIC_P : ppsr_pkg::MAGIC_BAD;
                            end else if (data_byte == ppsr_pkg::CH_MINUS) begin
                                neg_next = 1'b1;
                            end else if (data_byte != ppsr_pkg::CH_PLUS) begin
                                if (dig_take) begin
                                    numv_next = dig_value;
                                    dig_next  = 1'b1;
                                end else begin
                                    closed_next = 1'b1;
                                end
                            end
                        end
                    end
                    ppsr_pkg::PH_COMMENT: begin
                        if (data_byte == ppsr_pkg::CH_LF) begin
                            phase_next = ppsr_pkg::PH_SKIP;
                        end
                    end
                    ppsr_pkg::PH_TOKEN: begin
                        if (is_ws || is_hash) begin
                            fault_next = cf;
                            img_w_next = cw;
                            img_h_next = ch;
                            if (tok_reg == 2'd3) begin
                                res_valid = 1'b1;
                                if (cf != ppsr_pkg::FAULT_NONE) begin
                                    phase_next = ppsr_pkg::PH_DONE;
                                    res.kind   = (cf == ppsr_pkg::FAULT_BAD)
                                               ? ppsr_pkg::KIND_BAD : ppsr_pkg::KIND_SIZE;
                                    res.last   = 1'b1;
                                end else if (cw == 16'd0 || ch == 16'd0) begin
                                    phase_next = ppsr_pkg::PH_DONE;
                                    res.kind   = ppsr_pkg::KIND_HEADER;
                                    res.last   = 1'b1;
                                    res.column = cw;
                                    res.row    = ch;
                                end else begin
                                    // A hash closing the last token is the first red byte.
                                    phase_next = ppsr_pkg::PH_PIXELS;
                                    col_next   = '0;
                                    row_next   = '0;
                                    comp_next  = is_hash ? 2'd1 : 2'd0;
                                    if (is_hash) begin
                                        red_next = ppsr_pkg::CH_HASH;
                                    end
                                    res.kind   = ppsr_pkg::KIND_HEADER;
                                    res.column = cw;
                                    res.row    = ch;
                                end
                            end else begin
                                tok_next   = tok_reg + 2'd1;
                                phase_next = is_hash ? ppsr_pkg::PH_COMMENT
                                                     : ppsr_pkg::PH_SKIP;
                            end
                        end else if (tok_reg == 2'd0) begin
                            magic_next = (magic_reg == ppsr_pkg::MAGIC_P &&
                                          data_byte == ppsr_pkg::CH_SIX)
                                       ? ppsr_pkg::MAGIC_OK : ppsr_pkg::MAGIC_BAD;
                        end else if (dig_take) begin
                            numv_next = dig_value;
                            dig_next  = 1'b1;
                        end else begin
                            closed_next = 1'b1;
                        end
                    end
                    ppsr_pkg::PH_PIXELS: begin
                        unique case (comp_reg)
                            2'd0: begin
                                red_next  = data_byte;
                                comp_next = 2'd1;
                            end
                            2'd1: begin
                                green_next = data_byte;
                                comp_next  = 2'd2;
                            end
                            default: begin
                                comp_next  = 2'd0;
                                res_valid  = 1'b1;
                                res.kind   = ppsr_pkg::KIND_PIXEL;
                                res.last   = pix_last;
                                res.column = col_reg;
                                res.row    = row_reg;
                                res.red    = red_reg;
                                res.green  = green_reg;
                                res.blue   = data_byte;
                                if (pix_last) begin
                                    phase_next = ppsr_pkg::PH_DONE;
                                end else if (row_end) begin
                                    col_next = '0;
                                    row_next = row_inc[15:0];
                                end else begin
                                    col_next = col_inc[15:0];
                                end
                            end
                        endcase
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/ppsr_out_stage.sv =====
// ----------------------------------------------------------------------------
// ppsr_out_stage
// Result register. Holds one result until the downstream side takes it and
// lets the parser accept a new byte in the same cycle the result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppsr_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 in_valid,
    input  ppsr_pkg::result_t    in_result,
    output logic                 can_accept,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ppsr_pkg::result_t    out_result
);

    logic              valid_reg, valid_next;
    ppsr_pkg::result_t result_reg, result_next;

    assign can_accept = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (in_fire) begin
            // Accepting implies the held result is gone or leaving now.
            valid_next = in_valid;
            if (in_valid) begin
                result_next = in_result;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

// ===== rtl/core/ppm_p6_stream_reader.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_stream_reader
// Output: a result enters the output register at the clock edge that accepts
// the byte that causes it. Throughput: one file byte per cycle unless a held
// result is waiting and m_ready is low; the parse state updates in one pass.
// Reset: synchronous, active low; the parser returns to its start state and
// both size limits return to 65535. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppm_p6_stream_reader (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_file,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic        m_last_of_image,
    output logic [15:0] m_column,
    output logic [15:0] m_row,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue
);

    logic [15:0] max_width_reg, max_width_next;
    logic [15:0] max_height_reg, max_height_next;

    logic              in_fire;
    logic              res_valid;
    ppsr_pkg::result_t res;
    ppsr_pkg::result_t out_result;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;

    always_comb begin
        max_width_next  = max_width_reg;
        max_height_next = max_height_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == ppsr_pkg::CFG_MAX_WIDTH) begin
                max_width_next = cfg_wdata;
            end else if (cfg_index == ppsr_pkg::CFG_MAX_HEIGHT) begin
                max_height_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_width_reg  <= 16'hFFFF;
            max_height_reg <= 16'hFFFF;
        end else begin
            max_width_reg  <= max_width_next;
            max_height_reg <= max_height_next;
        end
    end

    ppsr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_data_byte),
        .end_of_file (s_end_of_file),
        .max_width   (max_width_reg),
        .max_height  (max_height_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    ppsr_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_valid   (res_valid),
        .in_result  (res),
        .can_accept (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (out_result)
    );

    assign m_result_kind   = out_result.kind;
    assign m_last_of_image = out_result.last;
    assign m_column        = out_result.column;
    assign m_row           = out_result.row;
    assign m_red           = out_result.red;
    assign m_green         = out_result.green;
    assign m_blue          = out_result.blue;

endmodule
